// ===== src/wfse_pkg.sv =====
package wfse_pkg;

    localparam int CHAN_W     = 8;
    localparam int DUTY_W     = 16;
    localparam int DATA_SLOTS = 3 * CHAN_W;
    localparam int CFG_IDX_W  = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FOR_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FOR_ZERO = 2'd2;

    localparam logic [CHAN_W-1:0] BRIGHTNESS_FULL = 8'd255;

    // One LED after brightness scaling, ready for the slot sequencer.
    typedef struct packed {
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] blue;
        logic              last_led;
    } t_led;

endpackage

// ===== src/wfse_scale.sv =====
module wfse_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [wfse_pkg::CHAN_W-1:0] i_red,
    input  logic [wfse_pkg::CHAN_W-1:0] i_green,
    input  logic [wfse_pkg::CHAN_W-1:0] i_blue,
    input  logic                        i_last_led,
    input  logic [wfse_pkg::CHAN_W-1:0] i_brightness,
    output logic                        o_valid,
    output wfse_pkg::t_led              o_led,
    input  logic                        i_take
);
    import wfse_pkg::*;

    logic              r_valid;
    logic [CHAN_W-1:0] r_red;
    logic [CHAN_W-1:0] r_green;
    logic [CHAN_W-1:0] r_blue;
    logic              r_last_led;
    logic              accept;

    // Exact divide by 255 for any product of two channel bytes: (p + (p >> 8) + 1) >> 8.
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] v,
                                                     input logic [CHAN_W-1:0] b);
        logic [2*CHAN_W-1:0] prod;
        logic [2*CHAN_W:0]   sum;
        prod = {{CHAN_W{1'b0}}, v} * {{CHAN_W{1'b0}}, b};
        sum  = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]}
             + {{(2*CHAN_W){1'b0}}, 1'b1};
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        o_led.green    = scale_chan(r_green, i_brightness);
        o_led.red      = scale_chan(r_red, i_brightness);
        o_led.blue     = scale_chan(r_blue, i_brightness);
        o_led.last_led = r_last_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red      <= i_red;
            r_green    <= i_green;
            r_blue     <= i_blue;
            r_last_led <= i_last_led;
        end
    end

endmodule

// ===== src/wfse_serializer.sv =====
module wfse_serializer #(
    parameter int RESET_SLOTS = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  wfse_pkg::t_led              i_led,
    output logic                        o_take,
    input  logic [wfse_pkg::DUTY_W-1:0] i_duty_for_one,
    input  logic [wfse_pkg::DUTY_W-1:0] i_duty_for_zero,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [wfse_pkg::DUTY_W-1:0] o_duty,
    output logic                        o_last_slot,
    output logic                        o_frame_end
);
    import wfse_pkg::*;

    localparam int TOTAL_SLOTS = DATA_SLOTS + RESET_SLOTS;
    localparam int CNT_W       = $clog2(TOTAL_SLOTS);
    localparam logic [CNT_W-1:0] LAST_DATA = CNT_W'(DATA_SLOTS - 1);
    localparam logic [CNT_W-1:0] LAST_ALL  = CNT_W'(TOTAL_SLOTS - 1);

    logic                  r_active;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_SLOTS-1:0] r_shift;
    logic                  r_last_led;
    logic                  r_o_valid;
    logic [DUTY_W-1:0]     r_o_duty;
    logic                  r_o_last;
    logic                  r_o_end;

    logic              advance;
    logic              emit;
    logic              load;
    logic              is_final;
    logic [DUTY_W-1:0] n_duty;

    assign advance  = !r_o_valid || i_ready;
    assign emit     = advance && r_active;
    assign is_final = r_last_led ? (r_cnt == LAST_ALL) : (r_cnt == LAST_DATA);
    // The next LED is taken in the same cycle as the final slot of this one.
    assign load     = advance && (!r_active || is_final);
    assign o_take   = load && i_valid;

    always_comb begin
        if (r_cnt <= LAST_DATA) begin
            n_duty = r_shift[DATA_SLOTS-1] ? i_duty_for_one : i_duty_for_zero;
        end else begin
            n_duty = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (advance) begin
                r_o_valid <= 1'b0;
            end
            if (load) begin
                r_active <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_duty <= n_duty;
            r_o_last <= is_final;
            r_o_end  <= is_final && r_last_led;
        end
        if (o_take) begin
            r_cnt      <= '0;
            r_shift    <= {i_led.green, i_led.red, i_led.blue};
            r_last_led <= i_led.last_led;
        end else if (emit) begin
            r_cnt   <= r_cnt + CNT_W'(1);
            r_shift <= {r_shift[DATA_SLOTS-2:0], 1'b0};
        end
    end

    assign o_valid     = r_o_valid;
    assign o_duty      = r_o_duty;
    assign o_last_slot = r_o_last;
    assign o_frame_end = r_o_end;

endmodule

// ===== src/ws2812_frame_slot_encoder_top.sv =====
// WS2812 frame slot encoder. Each input word is one LED color (red, green and
// blue bytes, with tlast set on the last LED of a frame). Every channel is
// scaled by the brightness register as value * brightness / 255, truncated,
// and the LED is then sent out as 24 PWM duty words in GRB order, most
// significant bit first: a one bit carries duty_for_one and a zero bit carries
// duty_for_zero. After the last LED of a frame, RESET_SLOTS words of zero duty
// follow as the latch pulse. On the output, tlast marks the final word caused
// by one LED and tuser marks the final word of the frame. One duty word leaves
// per cycle while m_axis_tready is high; the output slot sequencer sets that
// rate. An accepted LED passes the input register, the slot shift register
// and the output register before its first word appears, and the input
// register takes the next LED while the current one is still being sent.
module ws2812_frame_slot_encoder_top #(
    parameter int RESET_SLOTS = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [wfse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wfse_pkg::DUTY_W-1:0]    i_cfg_wdata,
    // Input stream of LED colors.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    input  logic                           s_axis_tlast,  // last_led
    // Output stream of PWM duty words.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // duty[15:0]
    output logic                           m_axis_tlast,  // last_slot
    output logic                           m_axis_tuser   // frame_end
);
    import wfse_pkg::*;

    // Configuration registers; writes to an unknown index are dropped.
    logic [CHAN_W-1:0] r_brightness;
    logic [DUTY_W-1:0] r_duty_for_one;
    logic [DUTY_W-1:0] r_duty_for_zero;

    // Scaled LED handed from the input stage to the slot sequencer.
    logic scaled_valid;
    t_led scaled_led;
    logic scaled_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness    <= BRIGHTNESS_FULL;
            r_duty_for_one  <= '0;
            r_duty_for_zero <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS: begin
                    r_brightness <= i_cfg_wdata[CHAN_W-1:0];
                end
                CFG_DUTY_FOR_ONE: begin
                    r_duty_for_one <= i_cfg_wdata;
                end
                CFG_DUTY_FOR_ZERO: begin
                    r_duty_for_zero <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register and brightness scaling.
    wfse_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_red        (s_axis_tdata[7:0]),
        .i_green      (s_axis_tdata[15:8]),
        .i_blue       (s_axis_tdata[23:16]),
        .i_last_led   (s_axis_tlast),
        .i_brightness (r_brightness),
        .o_valid      (scaled_valid),
        .o_led        (scaled_led),
        .i_take       (scaled_take)
    );

    // Bit-slot sequencer with the output register.
    wfse_serializer #(
        .RESET_SLOTS (RESET_SLOTS)
    ) u_serializer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (scaled_valid),
        .i_led           (scaled_led),
        .o_take          (scaled_take),
        .i_duty_for_one  (r_duty_for_one),
        .i_duty_for_zero (r_duty_for_zero),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_duty          (m_axis_tdata),
        .o_last_slot     (m_axis_tlast),
        .o_frame_end     (m_axis_tuser)
    );

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfse_pkg::*;

    // Latch length of the instance; the expected slots are built for it.
    localparam int LATCH_SLOTS = 40;

    // The index port is two bits wide, so one index names no register at all.
    // A write there must leave every register untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int GAP_PERCENT  = 18;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_LEDS   = 35;
    localparam int MAX_FRAME    = 8;

    // One LED color as it sits on the input bus.
    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last_led;
    } t_color;

    // One PWM duty word as it should leave the block.
    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              last_slot;
        logic              frame_end;
    } t_slot;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [DUTY_W-1:0]    i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // red[7:0], green[15:8], blue[23:16]
    logic                 s_axis_tlast  = 1'b0; // last_led
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;         // duty[15:0]
    logic                 m_axis_tlast;         // last_slot
    logic                 m_axis_tuser;         // frame_end

    // Our own copy of the three registers, updated on every write we issue.
    logic [CHAN_W-1:0] bright_q   = BRIGHTNESS_FULL;
    logic [DUTY_W-1:0] duty_one_q = '0;
    logic [DUTY_W-1:0] duty_zero_q = '0;

    t_color led_pending_q[$];  // colors waiting to be offered on the input bus
    t_slot  slot_due_q[$];     // duty words the block still owes us
    t_color led_seen;
    t_slot  slot_want;

    // While steady is set neither side inserts gaps or stalls.
    logic steady = 1'b0;

    int errors        = 0;
    int leds_sent     = 0;
    int frames_closed = 0;
    int words_checked = 0;
    int settings_seen = 0;

    ws2812_frame_slot_encoder_top #(
        .RESET_SLOTS(LATCH_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Brightness scaling: level * brightness / 255, truncated. The quotient
    // never exceeds 255, so it always fits back into one channel byte.
    function automatic logic [CHAN_W-1:0] dim(input logic [CHAN_W-1:0] level);
        logic [2*CHAN_W-1:0] product;
        product = {{CHAN_W{1'b0}}, level} * {{CHAN_W{1'b0}}, bright_q};
        return CHAN_W'(product / BRIGHTNESS_FULL);
    endfunction

    // Expands one accepted LED into the duty words it must produce: 24 data
    // slots in green, red, blue order with the most significant bit first,
    // then the zero-duty latch slots when the LED closes a frame.
    function automatic void encode_led(input t_color led);
        logic [DATA_SLOTS-1:0] bits;
        t_slot                 s;
        bits = {dim(led.green), dim(led.red), dim(led.blue)};
        for (int n = 0; n < DATA_SLOTS; n++) begin
            s.duty      = bits[DATA_SLOTS-1-n] ? duty_one_q : duty_zero_q;
            // With no latch slots the final data slot carries both markers;
            // otherwise the markers move to the end of the latch.
            s.last_slot = (n == DATA_SLOTS - 1) && (!led.last_led || LATCH_SLOTS == 0);
            s.frame_end = (n == DATA_SLOTS - 1) && led.last_led && (LATCH_SLOTS == 0);
            slot_due_q.push_back(s);
        end
        if (led.last_led) begin
            for (int i = 0; i < LATCH_SLOTS; i++) begin
                s.duty      = '0;
                s.last_slot = (i == LATCH_SLOTS - 1);
                s.frame_end = (i == LATCH_SLOTS - 1);
                slot_due_q.push_back(s);
            end
        end
    endfunction

    // Input driver. The word on the bus is predicted at the edge that takes
    // it; a new word is only loaded once the bus is empty or just accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                led_seen.red      = s_axis_tdata[7:0];
                led_seen.green    = s_axis_tdata[15:8];
                led_seen.blue     = s_axis_tdata[23:16];
                led_seen.last_led = s_axis_tlast;
                encode_led(led_seen);
                leds_sent++;
                if (s_axis_tlast) begin
                    frames_closed++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (led_pending_q.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= GAP_PERCENT)) begin
                    led_seen      = led_pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {led_seen.blue, led_seen.green, led_seen.red};
                    s_axis_tlast  <= led_seen.last_led;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor. It stalls the block at random and compares every word
    // it takes with the oldest duty word still owed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= GAP_PERCENT);
            if (m_axis_tvalid && m_axis_tready) begin
                words_checked++;
                if (slot_due_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("word %0d: unexpected duty %h last %b end %b",
                                 words_checked, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end else begin
                    slot_want = slot_due_q.pop_front();
                    if (m_axis_tdata !== slot_want.duty ||
                        m_axis_tlast !== slot_want.last_slot ||
                        m_axis_tuser !== slot_want.frame_end) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display({"word %0d: expected duty %h last %b end %b, ",
                                      "got duty %h last %b end %b"},
                                     words_checked, slot_want.duty, slot_want.last_slot,
                                     slot_want.frame_end, m_axis_tdata, m_axis_tlast,
                                     m_axis_tuser);
                        end
                    end
                end
            end
        end
    end

    // Register write through the configuration port, mirrored into our copy
    // with the same masking the block applies.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BRIGHTNESS: begin
                bright_q = value[CHAN_W-1:0];
            end
            CFG_DUTY_FOR_ONE: begin
                duty_one_q = value;
            end
            CFG_DUTY_FOR_ZERO: begin
                duty_zero_q = value;
            end
            default: begin
            end
        endcase
    endtask

    // Waits until every queued color has gone in and every owed word has
    // come out, then lets the pipeline settle. Sampled on the falling edge so
    // the clocked blocks have finished their work for the cycle.
    task automatic drain_idle();
        do begin
            @(negedge i_clk);
        end while (led_pending_q.size() != 0 || s_axis_tvalid || slot_due_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_led(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input logic last);
        t_color led;
        led.red      = r;
        led.green    = g;
        led.blue     = b;
        led.last_led = last;
        led_pending_q.push_back(led);
    endtask

    // Channel levels lean toward the two extremes now and then.
    function automatic logic [CHAN_W-1:0] rand_level();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? BRIGHTNESS_FULL : '0;
        end
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    initial begin
        int frame_len;
        int remaining;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: full brightness and zero for both duties, so every
        // data word must come out as zero duty.
        settings_seen++;
        push_led(8'hFF, 8'h00, 8'hA5, 1'b0);
        push_led(8'h3C, 8'hC3, 8'h81, 1'b1);
        drain_idle();

        // Full-scale one against zero duty makes each bit directly visible.
        // Distinct bytes per channel expose any slip in the GRB order.
        settings_seen++;
        set_reg(CFG_DUTY_FOR_ONE, 16'hFFFF);
        set_reg(CFG_DUTY_FOR_ZERO, 16'h0000);
        push_led(8'h00, 8'h00, 8'h00, 1'b0);
        push_led(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_led(8'h01, 8'h80, 8'h55, 1'b0);
        push_led(8'hAA, 8'h0F, 8'hF0, 1'b1);
        push_led(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain_idle();

        // Brightness zero blanks every channel.
        settings_seen++;
        set_reg(CFG_BRIGHTNESS, 16'h0000);
        push_led(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain_idle();

        // Brightness one leaves only a full channel at level one.
        settings_seen++;
        set_reg(CFG_BRIGHTNESS, 16'h0001);
        push_led(8'hFF, 8'hFE, 8'h01, 1'b0);
        drain_idle();

        // A wide brightness write keeps only its low byte; a write to the
        // unused index must change nothing.
        settings_seen++;
        set_reg(CFG_BRIGHTNESS, 16'h3A80);
        set_reg(CFG_UNMAPPED, 16'h1234);
        push_led(8'hFF, 8'hC8, 8'h07, 1'b1);
        push_led(8'h80, 8'h7F, 8'hFE, 1'b0);
        drain_idle();

        // Inverted duties: a one bit sends zero and a zero bit sends full.
        settings_seen++;
        set_reg(CFG_BRIGHTNESS, 16'h00FF);
        set_reg(CFG_DUTY_FOR_ONE, 16'h0000);
        set_reg(CFG_DUTY_FOR_ZERO, 16'hFFFF);
        push_led(8'h5A, 8'hC3, 8'h3C, 1'b1);
        push_led(8'h01, 8'h02, 8'h04, 1'b0);
        drain_idle();

        // Random frames, one register setting per phase. The first phases pin
        // brightness to its extremes, the third runs without any gaps.
        for (int phase = 0; phase < 6; phase++) begin
            settings_seen++;
            case (phase)
                0: set_reg(CFG_BRIGHTNESS, 16'h00FF);
                1: set_reg(CFG_BRIGHTNESS, 16'h0000);
                default: set_reg(CFG_BRIGHTNESS, DUTY_W'($urandom_range(0, 65535)));
            endcase
            set_reg(CFG_DUTY_FOR_ONE, DUTY_W'($urandom_range(0, 65535)));
            set_reg(CFG_DUTY_FOR_ZERO, DUTY_W'($urandom_range(0, 65535)));
            steady = (phase == 2);

            remaining = PHASE_LEDS;
            while (remaining > 0) begin
                frame_len = $urandom_range(1, MAX_FRAME);
                if (frame_len > remaining) begin
                    frame_len = remaining;
                end
                for (int k = 0; k < frame_len; k++) begin
                    push_led(rand_level(), rand_level(), rand_level(), k == frame_len - 1);
                end
                remaining -= frame_len;
                // Halfway through one phase the sender holds off until the
                // block has delivered everything it owes.
                if (phase == 4 && remaining < PHASE_LEDS / 2 && remaining + frame_len >=
                    PHASE_LEDS / 2) begin
                    drain_idle();
                end
            end
            drain_idle();
            steady = 1'b0;
        end

        if (slot_due_q.size() != 0) begin
            errors++;
            $display("%0d duty words never arrived", slot_due_q.size());
        end

        $display("Encoded %0d LEDs closing %0d frames under %0d register settings;",
                 leds_sent, frames_closed, settings_seen);
        $display("%0d duty words compared, %0d discrepancies.", words_checked, errors);
        if (errors == 0) begin
            $display("ws2812_frame_slot_encoder_top: match");
        end else begin
            $display("ws2812_frame_slot_encoder_top: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Run timed out with %0d duty words still owed.", slot_due_q.size());
        $display("ws2812_frame_slot_encoder_top: mismatch");
        $finish;
    end

endmodule
